/* rtl/assert_macros.svh */
// Assertion helpers. The enclosing module must have clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i outside reset.
`define RSDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rsds assertion failed");

// Same check with a caller-supplied message.
`define RSDS_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

/* rtl/rsds_pkg.sv */
package rsds_pkg;

  localparam int unsigned PosW           = 6;
  localparam int unsigned CardW          = 8;
  localparam int unsigned GenW           = 32;
  localparam int unsigned DeckEntriesDef = 52;

  // Generator step: g = g * LcgMul + LcgAdd (mod 2^32).
  localparam logic [GenW-1:0] LcgMul = 32'd214013;
  localparam logic [GenW-1:0] LcgAdd = 32'd2531011;

  // The partner position comes from bits 30..16 of the new generator state.
  localparam int unsigned PartLo = 16;
  localparam int unsigned PartW  = 15;

  // Shared multiplier: 32-bit by 22-bit operands, 54-bit product.
  localparam int unsigned MulBW = 22;
  localparam int unsigned MulPW = GenW + MulBW;

  // Reciprocal scale for the modulo by the deck size.
  localparam int unsigned RecipShift = 22;

  typedef enum logic {
    OpLoad    = 1'b0,
    OpShuffle = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [PosW-1:0]  position;
    logic [CardW-1:0] card;
  } in_item_t;

  typedef struct packed {
    logic [CardW-1:0] card_out;
    logic [PosW-1:0]  position_out;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic             en;
    logic [GenW-1:0]  a;
    logic [MulBW-1:0] b;
    logic [GenW-1:0]  c;
  } mul_op_t;

  typedef struct packed {
    logic             we;
    logic [PosW-1:0]  waddr;
    logic [CardW-1:0] wdata;
    logic             re;
    logic [PosW-1:0]  raddr_a;
    logic [PosW-1:0]  raddr_b;
  } deck_req_t;

endpackage

/* rtl/rsds_mul.sv */
module rsds_mul (
  input  logic                            clk_i,
  input  rsds_pkg::mul_op_t               op_i,
  output logic [rsds_pkg::MulPW-1:0]      prod_o
);
  import rsds_pkg::*;

  logic [MulPW-1:0] prod_d;
  logic [MulPW-1:0] prod_q;

  // One multiply-add per cycle; the result is held until the next enabled op.
  assign prod_d = MulPW'(op_i.a) * MulPW'(op_i.b) + MulPW'(op_i.c);

  always_ff @(posedge clk_i) begin
    if (op_i.en) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/rsds_deck_mem.sv */
module rsds_deck_mem #(
  parameter int unsigned DECK_ENTRIES = rsds_pkg::DeckEntriesDef
) (
  input  logic                        clk_i,
  input  rsds_pkg::deck_req_t         req_i,
  output logic [rsds_pkg::CardW-1:0]  rd_a_o,
  output logic [rsds_pkg::CardW-1:0]  rd_b_o
);
  import rsds_pkg::*;

  localparam int unsigned IdxW = $clog2(DECK_ENTRIES);

  logic [CardW-1:0] mem [DECK_ENTRIES];
  logic [CardW-1:0] rd_a_q;
  logic [CardW-1:0] rd_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[IdxW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_a_q <= mem[req_i.raddr_a[IdxW-1:0]];
      rd_b_q <= mem[req_i.raddr_b[IdxW-1:0]];
    end
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

/* rtl/random_swap_deck_shuffler_unit.sv */
// Load item: a card for a position inside the deck is written at the transfer; no result follows.
// Shuffle item: per deck position a generator step, reciprocal multiply, remainder
// multiply, two-port read and two writes, on one shared multiplier; then the cards
// are read out and emitted in position order. The next item is taken only once the
// last card is in the output register and the sequencer is back in idle.
// Reset (async, active low) clears the sequencer, output valid and generator state.
`include "assert_macros.svh"

module random_swap_deck_shuffler_unit #(
  parameter int unsigned DECK_ENTRIES = rsds_pkg::DeckEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Seed register: a write also reloads the generator.
  input  logic                          cfg_we_i,
  input  logic [rsds_pkg::GenW-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rsds_pkg::in_item_t            in_data_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rsds_pkg::out_item_t           out_data_o
);
  import rsds_pkg::*;

  localparam int unsigned     IdxW    = $clog2(DECK_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DECK_ENTRIES - 1);
  // ceil(2^22 / N) makes floor(x * RecipM / 2^22) the exact quotient for any
  // 15-bit x as long as N is between 2 and 64.
  localparam logic [MulBW-1:0] RecipM =
    MulBW'((2 ** RecipShift + DECK_ENTRIES - 1) / DECK_ENTRIES);

  // Sequencer states. One pass of StLcg..StWr2 handles one deck position;
  // StEmitRd/StEmitOut read the deck out, one card per pass.
  typedef enum logic [8:0] {
    StIdle    = 9'b000000001,
    StLcg     = 9'b000000010,
    StRecip   = 9'b000000100,
    StMod     = 9'b000001000,
    StRead    = 9'b000010000,
    StWr1     = 9'b000100000,
    StWr2     = 9'b001000000,
    StEmitRd  = 9'b010000000,
    StEmitOut = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   part_q, part_d;
  logic [PartW-1:0]  x_q, x_d;
  logic [GenW-1:0]   gen_q, gen_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  mul_op_t           mul_op;
  logic [MulPW-1:0]  mul_prod;
  deck_req_t         deck_req;
  logic [CardW-1:0]  rd_a;
  logic [CardW-1:0]  rd_b;

  logic              in_xfer;
  logic              out_xfer;
  logic              out_free;
  logic [PartW-1:0]  remainder;
  logic              load_in_range;

  rsds_mul u_mul (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (mul_prod)
  );

  rsds_deck_mem #(
    .DECK_ENTRIES (DECK_ENTRIES)
  ) u_deck_mem (
    .clk_i  (clk_i),
    .req_i  (deck_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // The block only takes an item while the sequencer is idle. The output
  // register decouples the last card from the next input transfer.
  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  // The quotient product q*N is in the multiplier during StRead, so the
  // remainder x - q*N is always below N and fits the index width.
  assign remainder = x_q - mul_prod[PartW-1:0];

  // Loads beyond the deck are dropped.
  assign load_in_range =
    ({1'b0, in_data_i.position} < (PosW + 1)'(DECK_ENTRIES));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    part_d      = part_q;
    x_d         = x_q;
    gen_d       = gen_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    mul_op      = '0;
    deck_req    = '0;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_data_i.operation == OpShuffle) begin
            idx_d   = '0;
            state_d = StLcg;
          end else if (load_in_range) begin
            deck_req.we    = 1'b1;
            deck_req.waddr = in_data_i.position;
            deck_req.wdata = in_data_i.card;
          end
        end
      end
      StLcg: begin
        // Step the generator on the shared multiplier.
        mul_op.en = 1'b1;
        mul_op.a  = gen_q;
        mul_op.b  = MulBW'(LcgMul);
        mul_op.c  = LcgAdd;
        state_d   = StRecip;
      end
      StRecip: begin
        // Keep the new state and scale its 15 random bits by 1/N.
        gen_d     = mul_prod[GenW-1:0];
        x_d       = mul_prod[PartLo +: PartW];
        mul_op.en = 1'b1;
        mul_op.a  = GenW'(mul_prod[PartLo +: PartW]);
        mul_op.b  = RecipM;
        state_d   = StMod;
      end
      StMod: begin
        // Multiply the quotient back by N.
        mul_op.en = 1'b1;
        mul_op.a  = GenW'(mul_prod[RecipShift +: PartW]);
        mul_op.b  = MulBW'(DECK_ENTRIES);
        state_d   = StRead;
      end
      StRead: begin
        part_d           = remainder[IdxW-1:0];
        deck_req.re      = 1'b1;
        deck_req.raddr_a = PosW'(idx_q);
        deck_req.raddr_b = PosW'(remainder[IdxW-1:0]);
        state_d          = StWr1;
      end
      StWr1: begin
        deck_req.we    = 1'b1;
        deck_req.waddr = PosW'(idx_q);
        deck_req.wdata = rd_b;
        state_d        = StWr2;
      end
      StWr2: begin
        // A self swap writes the same value twice and is harmless.
        deck_req.we    = 1'b1;
        deck_req.waddr = PosW'(part_q);
        deck_req.wdata = rd_a;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = StEmitRd;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StLcg;
        end
      end
      StEmitRd: begin
        deck_req.re      = 1'b1;
        deck_req.raddr_a = PosW'(idx_q);
        deck_req.raddr_b = PosW'(idx_q);
        state_d          = StEmitOut;
      end
      StEmitOut: begin
        // Wait here until the output register can take the card.
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.card_out     = rd_a;
          out_d.position_out = PosW'(idx_q);
          out_d.last         = (idx_q == LastIdx);
          if (idx_q == LastIdx) begin
            idx_d   = '0;
            state_d = StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StEmitRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      // A seed write reloads the generator; the user must issue it only while idle, as the block does not enforce this.
      if (cfg_we_i) begin
        gen_q <= cfg_wdata_i;
      end else begin
        gen_q <= gen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    x_q    <= x_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result can only come from the emit state.
  `RSDS_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == StEmitOut))
  // The last flag marks the final deck position and nothing else.
  `RSDS_ASSERT_MSG(a_last_pos, (out_valid_q && out_q.last) |-> (out_q.position_out == PosW'(DECK_ENTRIES - 1)), "last flag on wrong position")
  // Every deck write lands inside the deck.
  `RSDS_ASSERT(a_write_in_deck, deck_req.we |-> ({1'b0, deck_req.waddr} < (PosW + 1)'(DECK_ENTRIES)))
  // The partner position from the modulo step is a valid deck position.
  `RSDS_ASSERT_MSG(a_partner_range, (state_q == StWr1) |-> ({1'b0, part_q} < (IdxW + 1)'(DECK_ENTRIES)), "partner position out of range")

endmodule

/* tb/random_swap_deck_shuffler_unit_test.sv */
`timescale 1ns / 1ps

module random_swap_deck_shuffler_unit_test;
  import rsds_pkg::*;

  // The deck size under test and the generator constants of the shuffle.
  localparam int unsigned DeckSize  = 52;
  localparam logic [31:0] LcgMult   = 32'd214013;
  localparam logic [31:0] LcgInc    = 32'd2531011;
  // Quiet cycles after the last dealt card before a seed write or the end of
  // the run; a load is already complete at its transfer.
  localparam int unsigned LoadSettle = 16;
  // Cycles without any transfer before the run is declared hung. A shuffle
  // keeps both channels quiet while it walks the deck, before it deals.
  localparam int unsigned HangLimit  = 5000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  random_swap_deck_shuffler_unit #(
    .DECK_ENTRIES(DeckSize)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the block's state: the deck and the generator.
  logic [CardW-1:0] deck_model [DeckSize];
  logic [31:0]      lcg_model;

  // Cards still to be dealt, oldest first.
  out_item_t dealt_q [$];

  int unsigned fail_cnt;
  // When clear, neither side inserts idle bursts.
  bit          idle_en;

  // One row of the directed stimulus. When pin is set, every dealt card is
  // expected to equal pin_card; this is used only where the deck is uniform.
  typedef struct packed {
    op_e              op;
    logic [PosW-1:0]  pos;
    logic [CardW-1:0] card;
    logic             pin;
    logic [CardW-1:0] pin_card;
  } stim_row_t;

  localparam int unsigned PlanLen = 18;

  stim_row_t plan [PlanLen] = '{
    // The deck is all 8'hFF here, so any shuffle deals all 8'hFF.
    '{OpShuffle, 6'd0,  8'h00, 1'b1, 8'hFF},
    // Loads past the end of the deck must leave it untouched.
    '{OpLoad,    6'd52, 8'h00, 1'b0, 8'h00},
    '{OpLoad,    6'd63, 8'h00, 1'b0, 8'h00},
    // A shuffle ignores its position and card fields.
    '{OpShuffle, 6'd63, 8'h00, 1'b1, 8'hFF},
    // Now break the uniform deck with edge values at edge positions.
    '{OpLoad,    6'd0,  8'h00, 1'b0, 8'h00},
    '{OpLoad,    6'd51, 8'h00, 1'b0, 8'h00},
    '{OpLoad,    6'd1,  8'h01, 1'b0, 8'h00},
    '{OpLoad,    6'd50, 8'h80, 1'b0, 8'h00},
    '{OpLoad,    6'd32, 8'h7F, 1'b0, 8'h00},
    '{OpLoad,    6'd31, 8'h55, 1'b0, 8'h00},
    '{OpLoad,    6'd16, 8'hAA, 1'b0, 8'h00},
    '{OpShuffle, 6'd0,  8'hFF, 1'b0, 8'h00},
    '{OpLoad,    6'd63, 8'h12, 1'b0, 8'h00},
    '{OpShuffle, 6'd51, 8'h55, 1'b0, 8'h00},
    // Two shuffles back to back: the generator carries on between them.
    '{OpShuffle, 6'd42, 8'hAA, 1'b0, 8'h00},
    '{OpLoad,    6'd8,  8'hFE, 1'b0, 8'h00},
    '{OpLoad,    6'd53, 8'h3C, 1'b0, 8'h00},
    '{OpShuffle, 6'd21, 8'hC3, 1'b0, 8'h00}
  };

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Walks the deck once, swapping each position with a partner drawn from
  // bits 30..16 of the stepped generator. A partner equal to the current
  // position is a self swap and leaves the deck as it was.
  task automatic model_shuffle();
    logic [31:0]      pick;
    logic [CardW-1:0] held;
    for (int i = 0; i < DeckSize; i++) begin
      lcg_model = lcg_model * LcgMult + LcgInc;
      pick = {17'd0, lcg_model[30:16]} % DeckSize;
      held = deck_model[i];
      deck_model[i] = deck_model[pick];
      deck_model[pick] = held;
    end
  endtask

  // Applies one accepted item to the shadow state and queues the cards that
  // the block must deal for it. A load deals nothing.
  task automatic apply_item(input in_item_t item, input logic pin,
                            input logic [CardW-1:0] pin_card);
    out_item_t want;
    if (item.operation == OpLoad) begin
      if (item.position < DeckSize) deck_model[item.position] = item.card;
    end else begin
      model_shuffle();
      for (int i = 0; i < DeckSize; i++) begin
        want.card_out     = pin ? pin_card : deck_model[i];
        want.position_out = i[PosW-1:0];
        want.last         = (i == DeckSize - 1);
        dealt_q.push_back(want);
      end
    end
  endtask

  // Presents one item and holds it until the transfer. An idle burst may come
  // first; without one, valid simply stays high and only the payload changes,
  // so valid never gets two updates in one time step.
  task automatic send_item(input in_item_t item, input logic pin,
                           input logic [CardW-1:0] pin_card);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    apply_item(item, pin, pin_card);
  endtask

  // Drops valid and waits until every queued card has been dealt, then waits
  // out the LoadSettle quiet period so that stray results would show up.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (dealt_q.size() != 0) @(posedge clk_i);
    repeat (LoadSettle) @(posedge clk_i);
  endtask

  // Seed writes happen only with the block idle; they also reload the generator.
  task automatic write_seed(input logic [31:0] seed);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lcg_model = seed;
  endtask

  // Mostly in-range loads with random cards, a good share of shuffles with
  // random (ignored) fields, and some loads aimed past the end of the deck.
  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned roll;
    roll           = $urandom_range(0, 99);
    item.card      = CardW'($urandom_range(0, 255));
    item.position  = PosW'($urandom_range(0, DeckSize - 1));
    item.operation = OpLoad;
    if (roll < 25) begin
      item.operation = OpShuffle;
      item.position  = PosW'($urandom_range(0, 63));
    end else if (roll < 33) begin
      item.position = PosW'($urandom_range(DeckSize, 63));
    end
    return item;
  endfunction

  // Result side: stall in random bursts while idling is on, and compare each
  // dealt card with the oldest one queued.
  initial begin
    int unsigned stall_left;
    out_item_t   got;
    out_item_t   want;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (dealt_q.size() == 0) begin
          $error("unexpected result: card_out=%0h position_out=%0d last=%0b",
                 got.card_out, got.position_out, got.last);
          fail_cnt++;
        end else begin
          want = dealt_q.pop_front();
          if (got.card_out !== want.card_out) begin
            $error("card_out: expected %0h, got %0h", want.card_out, got.card_out);
            fail_cnt++;
          end
          if (got.position_out !== want.position_out) begin
            $error("position_out: expected %0d, got %0d",
                   want.position_out, got.position_out);
            fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fail_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog: any transfer on either channel resets the count of quiet cycles.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= HangLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    in_item_t    item;
    logic [31:0] seeds [3];
    int unsigned seg_len [3];
    fail_cnt    = 0;
    idle_en     = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    lcg_model   = '0;
    for (int i = 0; i < DeckSize; i++) deck_model[i] = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry must be written before the first shuffle. Filling the deck
    // with one value makes the first shuffles deal a known, uniform deck.
    for (int i = 0; i < DeckSize; i++) begin
      item.operation = OpLoad;
      item.position  = i[PosW-1:0];
      item.card      = 8'hFF;
      send_item(item, 1'b0, 8'h00);
    end

    // Directed part, run on the reset seed.
    foreach (plan[r]) begin
      item.operation = plan[r].op;
      item.position  = plan[r].pos;
      item.card      = plan[r].card;
      send_item(item, plan[r].pin, plan[r].pin_card);
    end

    // Random part in three segments, each under its own seed. The extremes of
    // the seed come first; the last segment runs with no idling at all.
    seeds[0]   = 32'hFFFF_FFFF;
    seeds[1]   = 32'h0000_0000;
    seeds[2]   = $urandom();
    seg_len[0] = 16;
    seg_len[1] = 12;
    seg_len[2] = 12;
    for (int s = 0; s < 3; s++) begin
      write_seed(seeds[s]);
      idle_en = (s < 2);
      for (int n = 0; n < seg_len[s]; n++) begin
        // Partway through the first segment the sender holds off until the
        // whole deck has been dealt, then carries on with the same seed.
        if (s == 0 && n == 8) drain_and_settle();
        send_item(random_item(), 1'b0, 8'h00);
      end
    end

    // Wait for the last deal, then a little longer to catch stray results.
    drain_and_settle();
    if (fail_cnt == 0 && dealt_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* random_swap_deck_shuffler_unit.f */
+incdir+rtl
rtl/rsds_pkg.sv
rtl/rsds_mul.sv
rtl/rsds_deck_mem.sv
rtl/random_swap_deck_shuffler_unit.sv
tb/random_swap_deck_shuffler_unit_test.sv
